// ----- src/sitda_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// Command/status structs, controller states and character codes for the
// signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 6;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int STEP_W   = 4;
    localparam int STEPS    = VALUE_W / STEP_W;
    localparam int CNT_W    = $clog2(STEPS);
    localparam int IDX_W    = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic neg;
        logic digit_last;
        logic out_free;
    } sts_t;

endpackage

// ----- src/sitda_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_ctrl: conversion sequencer
// Accepts an input transaction, runs the BCD conversion, then issues the
// sign (negative values only) and digit characters one per free output slot.
// ----------------------------------------------------------------------------
module sitda_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sitda_pkg::sts_t  sts,
    output sitda_pkg::cmd_t  cmd
);

    sitda_pkg::state_t state_reg;
    sitda_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sitda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sitda_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV: begin
                if (sts.conv_last) begin
                    state_next = sts.neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
                end
            end
            sitda_pkg::ST_SIGN: begin
                if (sts.out_free) begin
                    state_next = sitda_pkg::ST_DIGIT;
                end
            end
            sitda_pkg::ST_DIGIT: begin
                if (sts.out_free && sts.digit_last) begin
                    state_next = sitda_pkg::ST_IDLE;
                end
            end
            default: state_next = sitda_pkg::ST_IDLE;
        endcase
    end

    // Hold ready low while reset is asserted so no transaction is dropped
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            sitda_pkg::ST_IDLE: begin
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
            end
            sitda_pkg::ST_CONV:  cmd.conv       = 1'b1;
            sitda_pkg::ST_SIGN:  cmd.emit_sign  = sts.out_free;
            sitda_pkg::ST_DIGIT: cmd.emit_digit = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- src/sitda_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_dpath: conversion datapath
// Magnitude register, four-bit-per-cycle double dabble, digit pointer and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module sitda_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [sitda_pkg::VALUE_W-1:0] s_value,
    output logic [sitda_pkg::CHAR_W-1:0]       m_character,
    output logic                               m_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    input  sitda_pkg::cmd_t                    cmd,
    output sitda_pkg::sts_t                    sts
);

    logic [sitda_pkg::VALUE_W-1:0] bits_reg;
    logic [sitda_pkg::BCD_W-1:0]   bcd_reg;
    logic [sitda_pkg::BCD_W-1:0]   bcd_next;
    logic [sitda_pkg::CNT_W-1:0]   cnt_reg;
    logic [sitda_pkg::IDX_W-1:0]   idx_reg;
    logic [sitda_pkg::IDX_W-1:0]   top_idx;
    logic                          neg_reg;
    logic [sitda_pkg::CHAR_W-1:0]  char_reg;
    logic                          last_reg;
    logic                          valid_reg;
    logic [3:0]                    digit;

    // Four adjust-and-shift steps of double dabble per cycle
    always_comb begin
        logic [sitda_pkg::BCD_W-1:0] acc;
        acc = bcd_reg;
        for (int j = 0; j < sitda_pkg::STEP_W; j++) begin
            for (int n = 0; n < sitda_pkg::DIGITS; n++) begin
                if (acc[4*n +: 4] >= 4'd5) begin
                    acc[4*n +: 4] = acc[4*n +: 4] + 4'd3;
                end
            end
            acc = {acc[sitda_pkg::BCD_W-2:0], bits_reg[sitda_pkg::VALUE_W-1-j]};
        end
        bcd_next = acc;
    end

    // Highest nonzero digit of the finished BCD word; zero gives digit 0
    always_comb begin
        top_idx = '0;
        for (int n = 0; n < sitda_pkg::DIGITS; n++) begin
            if (bcd_next[4*n +: 4] != 4'd0) begin
                top_idx = n[sitda_pkg::IDX_W-1:0];
            end
        end
    end

    assign digit = bcd_reg[4*idx_reg +: 4];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg  <= s_value[sitda_pkg::VALUE_W-1];
            bits_reg <= s_value[sitda_pkg::VALUE_W-1] ? (~s_value + 1'b1) : s_value;
            bcd_reg  <= '0;
            cnt_reg  <= '0;
        end else if (cmd.conv) begin
            bits_reg <= bits_reg << sitda_pkg::STEP_W;
            bcd_reg  <= bcd_next;
            cnt_reg  <= cnt_reg + 1'b1;
            idx_reg  <= top_idx;
        end else if (cmd.emit_digit) begin
            idx_reg  <= idx_reg - 1'b1;
        end
    end

    // Output register: load on emit, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            char_reg <= sitda_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg <= sitda_pkg::CHAR_ZERO + {2'b00, digit};
            last_reg <= (idx_reg == '0);
        end
    end

    assign sts.conv_last  = (cnt_reg == sitda_pkg::CNT_W'(sitda_pkg::STEPS - 1));
    assign sts.neg        = neg_reg;
    assign sts.digit_last = (idx_reg == '0);
    assign sts.out_free   = !valid_reg || m_ready;

    assign m_character = char_reg;
    assign m_last      = last_reg;
    assign m_valid     = valid_reg;

endmodule

// ----- src/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal text
// Emits the decimal ASCII characters, MSD first, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Sequence: the input transaction loads the magnitude register, the
//   conversion state runs the double dabble, then the first character is
//   loaded into the output register; behind a minus sign the first digit
//   follows in the next free output slot. A value gives 1 to 11 characters;
//   a new value is accepted only after the last character of the previous
//   one has been issued.
// Reset: aresetn, synchronous, active low; clears the sequencer and the
//   output valid. No state is kept between values.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel: one integer per transaction
    input  logic signed [sitda_pkg::VALUE_W-1:0] s_value,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    // result channel: one character per transaction
    output logic [sitda_pkg::CHAR_W-1:0]         m_character,
    output logic                                 m_last,
    output logic                                 m_valid,
    input  logic                                 m_ready
);

    sitda_pkg::cmd_t cmd;
    sitda_pkg::sts_t sts;

    // Sequencer: accept only when idle, then convert, then stream characters
    sitda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: magnitude, BCD word, digit pointer, output register
    sitda_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .m_character (m_character),
        .m_last      (m_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ----- src/sitda_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_checker: port-level checks
// Watches the ports of the converter over time; bound to the top level.
// ----------------------------------------------------------------------------
module sitda_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic [sitda_pkg::CHAR_W-1:0]         m_character,
    input logic                                 m_last,
    input logic                                 m_valid,
    input logic                                 m_ready
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("stalled result transaction changed");

    a_char_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == sitda_pkg::CHAR_MINUS)
                 || (m_character >= sitda_pkg::CHAR_ZERO && m_character <= 6'd57))
        else $error("character code out of range");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_character == sitda_pkg::CHAR_MINUS |-> !m_last)
        else $error("minus sign ends a run");

    a_busy_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready in the middle of a run");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_character (m_character),
    .m_last      (m_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready)
);
